@@ sv/bfch_pkg.sv @@
// Package for the brute-force convex hull block.
// Holds sizes, the point type and the controller state enum; no dependencies.
`default_nettype none
package bfch_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef enum logic [3:0] {
    StLoad,
    StClear,
    StTestI,
    StTestK,
    StTestWait,
    StTestEval,
    StSelScan,
    StSelWait,
    StSelEval,
    StEmit,
    StEmitNone
  } state_e;

  // Signed (x, y) ordering key; unsigned compare of keys equals lexicographic order.
  function automatic logic [31:0] order_key(input point_t p);
    order_key = {p.x, p.y} ^ 32'h8000_8000;
  endfunction
endpackage
`default_nettype wire

@@ sv/bfch_cross.sv @@
// Registered cross product sign unit: a registered difference stage, a registered
// multiply stage and a combinational subtract. Depends on bfch_pkg.
`default_nettype none
module bfch_cross (
  input  wire logic             clk_i,
  input  wire bfch_pkg::point_t a_i,
  input  wire bfch_pkg::point_t b_i,
  input  wire bfch_pkg::point_t c_i,
  output logic                  neg_o
);
  logic signed [16:0] dxb_q, dyb_q, dxc_q, dyc_q;
  logic signed [33:0] p1_q, p2_q;

  // neg_o follows the operands through the difference and multiply registers.
  always_ff @(posedge clk_i) begin
    dxb_q <= 17'(b_i.x) - 17'(a_i.x);
    dyb_q <= 17'(b_i.y) - 17'(a_i.y);
    dxc_q <= 17'(c_i.x) - 17'(a_i.x);
    dyc_q <= 17'(c_i.y) - 17'(a_i.y);
    p1_q  <= dxb_q * dyc_q;
    p2_q  <= dyb_q * dxc_q;
  end

  logic signed [34:0] diff;
  assign diff  = 35'(p1_q) - 35'(p2_q);
  assign neg_o = diff[34];
endmodule
`default_nettype wire

@@ sv/brute_force_convex_hull_top.sv @@
// Top level of the brute-force convex hull block: point memory, hull marks,
// control sequencer. Depends on bfch_pkg and bfch_cross.
`default_nettype none
// Usage: a point transfer happens at a clock edge with start high and busy
// low. Points are stored in arrival order in a 64-entry synchronous memory; a
// point past capacity is dropped and sets the dropped flag. A point with
// last_point_i high starts the search and raises busy.
// Search: for every ordered pair (i, j) every other k is tested with an exact
// cross product. Points are read from two copies of the store through
// registered reads, and for each k the read and the two register stages of the
// cross unit are waited out before its sign is used, so a new k is not started
// until the last one is decided; the k scan stops early at the first point
// strictly to the right.
// Emission: the marked points are scanned repeatedly, each scan picking the
// smallest key larger than the last one taken, which removes duplicates and
// sorts. A first round of d+1 scans counts the d distinct hull points and a
// second round of d scans emits them; each scan passes every point in turn
// through the read, wait and evaluate states.
// Each result transfer is shown for one cycle with result_valid_o; the receiver
// cannot stall, so no buffering is needed. With no hull point a single result
// with none_found_o set is given. Reset clears the point count, flags and marks;
// the memories need no clearing.
module brute_force_convex_hull_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] px_i,
  input  wire logic signed [15:0] py_i,
  input  wire logic               last_point_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      hull_x_o,
  output logic signed [15:0]      hull_y_o,
  output logic [6:0]              hull_count_o,
  output logic                    none_found_o,
  output logic                    dropped_o,
  output logic                    end_of_answer_o
);
  localparam int IW = bfch_pkg::IdxW;
  localparam int CW = bfch_pkg::CntW;

  bfch_pkg::state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d, emitted_q, emitted_d;
  logic          have_q, have_d, found_q, found_d, ok_q, ok_d;
  logic [31:0]   last_q, last_d, best_q, best_d;
  logic [1:0]    wait_q, wait_d;
  logic [bfch_pkg::MaxPoints-1:0] mark_q, mark_d;

  // Two memory copies with identical writes, so two points read per cycle.
  bfch_pkg::point_t mem_a [bfch_pkg::MaxPoints];
  bfch_pkg::point_t mem_b [bfch_pkg::MaxPoints];
  bfch_pkg::point_t rd_a_q, rd_b_q, pi_q, pi_d, pj_q, pj_d;
  logic [IW-1:0]    ra_addr, rb_addr;
  logic             wr_en;
  bfch_pkg::point_t wr_pt;

  logic accept;
  assign accept = start && !busy;
  assign wr_en  = accept && (n_q < CW'(bfch_pkg::MaxPoints));
  assign wr_pt  = '{x: px_i, y: py_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[n_q[IW-1:0]] <= wr_pt;
      mem_b[n_q[IW-1:0]] <= wr_pt;
    end
    rd_a_q <= mem_a[ra_addr];
    rd_b_q <= mem_b[rb_addr];
  end

  logic neg;
  bfch_cross u_cross (.clk_i(clk_i), .a_i(pi_q), .b_i(pj_q), .c_i(rd_a_q), .neg_o(neg));

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfch_pkg::StLoad;
      n_q <= '0; ovf_q <= 1'b0; mark_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; cnt_q <= '0; emitted_q <= '0;
      have_q <= 1'b0; found_q <= 1'b0; ok_q <= 1'b0; wait_q <= '0;
    end else begin
      state_q <= state_d;
      n_q <= n_d; ovf_q <= ovf_d; mark_q <= mark_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; cnt_q <= cnt_d; emitted_q <= emitted_d;
      have_q <= have_d; found_q <= found_d; ok_q <= ok_d; wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d; best_q <= best_d; pi_q <= pi_d; pj_q <= pj_d;
  end

  logic [IW-1:0] nm1;
  assign nm1 = IW'(n_q - CW'(1));
  logic [31:0] key_rd;
  assign key_rd = bfch_pkg::order_key(rd_a_q);

  always_comb begin
    state_d = state_q;
    n_d = n_q; ovf_d = ovf_q; mark_d = mark_q;
    i_d = i_q; j_d = j_q; k_d = k_q; cnt_d = cnt_q; emitted_d = emitted_q;
    have_d = have_q; found_d = found_q; ok_d = ok_q; wait_d = wait_q;
    last_d = last_q; best_d = best_q; pi_d = pi_q; pj_d = pj_q;
    ra_addr = k_q; rb_addr = j_q;
    case (state_q)
      bfch_pkg::StLoad: begin
        if (accept) begin
          if (wr_en) n_d = n_q + CW'(1);
          else ovf_d = 1'b1;
          if (last_point_i) state_d = bfch_pkg::StClear;
        end
      end
      bfch_pkg::StClear: begin
        mark_d = '0; i_d = '0; j_d = '0; cnt_d = '0; have_d = 1'b0;
        state_d = (n_q < CW'(2)) ? bfch_pkg::StEmitNone : bfch_pkg::StTestI;
      end
      bfch_pkg::StTestI: begin
        // Fetch pi and pj.
        ra_addr = i_q; rb_addr = j_q;
        k_d = '0; ok_d = 1'b1; wait_d = '0;
        state_d = bfch_pkg::StTestK;
      end
      bfch_pkg::StTestK: begin
        if (wait_q == 2'd0) begin
          pi_d = rd_a_q; pj_d = rd_b_q;
        end
        if (i_q == j_q) begin
          state_d = bfch_pkg::StTestEval;
        end else if (k_q == i_q || k_q == j_q) begin
          if (k_q == nm1) state_d = bfch_pkg::StTestEval;
          else k_d = k_q + IW'(1);
          wait_d = 2'd1;
        end else begin
          ra_addr = k_q; wait_d = '0;
          state_d = bfch_pkg::StTestWait;
        end
      end
      bfch_pkg::StTestWait: begin
        // Read data then two cross stages.
        wait_d = wait_q + 2'd1;
        if (wait_q == 2'd2) begin
          if (neg) ok_d = 1'b0;
          if (neg || k_q == nm1) state_d = bfch_pkg::StTestEval;
          else begin
            k_d = k_q + IW'(1); wait_d = 2'd1;
            state_d = bfch_pkg::StTestK;
          end
        end else if (wait_q == 2'd0) begin
          ra_addr = k_q;
        end
      end
      bfch_pkg::StTestEval: begin
        if (i_q != j_q && ok_q) mark_d[i_q] = 1'b1;
        state_d = bfch_pkg::StTestI;
        if (j_q == nm1) begin
          j_d = '0;
          if (i_q == nm1) begin
            i_d = '0; emitted_d = '0; found_d = 1'b0; best_d = '1;
            state_d = bfch_pkg::StSelScan;
          end else i_d = i_q + IW'(1);
        end else j_d = j_q + IW'(1);
      end
      bfch_pkg::StSelScan: begin
        ra_addr = i_q;
        state_d = bfch_pkg::StSelWait;
      end
      bfch_pkg::StSelWait: begin
        // Hold the read address so the data stays on point i.
        ra_addr = i_q;
        state_d = bfch_pkg::StSelEval;
      end
      bfch_pkg::StSelEval: begin
        if (mark_q[i_q] && (!have_q || key_rd > last_q) && (!found_q || key_rd < best_q)) begin
          best_d = key_rd; found_d = 1'b1;
        end
        if (i_q == nm1) begin
          i_d = '0;
          if (found_d) begin
            last_d = best_d; have_d = 1'b1;
            if (emitted_q == '0) cnt_d = cnt_q + CW'(1);
            state_d = (emitted_q == '0) ? bfch_pkg::StSelScan : bfch_pkg::StEmit;
            found_d = 1'b0; best_d = '1;
          end else if (emitted_q == '0) begin
            // Counting pass done: now emit.
            emitted_d = CW'(1); have_d = 1'b0;
            state_d = (cnt_q == '0) ? bfch_pkg::StEmitNone : bfch_pkg::StSelScan;
          end else begin
            state_d = bfch_pkg::StLoad;
            n_d = '0; ovf_d = 1'b0; mark_d = '0;
          end
        end else begin
          i_d = i_q + IW'(1);
          state_d = bfch_pkg::StSelScan;
        end
      end
      bfch_pkg::StEmit: begin
        emitted_d = emitted_q + CW'(1);
        if (emitted_q == cnt_q) begin
          state_d = bfch_pkg::StLoad;
          n_d = '0; ovf_d = 1'b0; mark_d = '0;
        end else state_d = bfch_pkg::StSelScan;
      end
      bfch_pkg::StEmitNone: begin
        state_d = bfch_pkg::StLoad;
        n_d = '0; ovf_d = 1'b0; mark_d = '0;
      end
      default: state_d = bfch_pkg::StLoad;
    endcase
  end

  // Outputs.
  logic [31:0] pt_out;
  assign pt_out = last_q ^ 32'h8000_8000;
  always_comb begin
    busy = (state_q != bfch_pkg::StLoad);
    result_valid_o = 1'b0; none_found_o = 1'b0; end_of_answer_o = 1'b0;
    hull_x_o = '0; hull_y_o = '0; hull_count_o = cnt_q; dropped_o = ovf_q;
    case (state_q)
      bfch_pkg::StEmit: begin
        result_valid_o = 1'b1;
        hull_x_o = pt_out[31:16]; hull_y_o = pt_out[15:0];
        end_of_answer_o = (emitted_q == cnt_q);
      end
      bfch_pkg::StEmitNone: begin
        result_valid_o = 1'b1; none_found_o = 1'b1; end_of_answer_o = 1'b1;
        hull_count_o = '0;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result while idle");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(bfch_pkg::MaxPoints)) else $error("point count past capacity");
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && end_of_answer_o) |=> !busy) else $error("not idle after answer");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && none_found_o) |-> (hull_count_o == '0)) else $error("none with count");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the brute-force convex hull block.
// Depends on bfch_pkg and brute_force_convex_hull_top; predicts every answer in place.
`default_nettype none
module tb_top;
  localparam longint CycleLimit = 40_000_000;

  // One point transfer as the driver presents it.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_xfer_t;

  // One expected hull result.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [6:0]         count;
    logic               none;
    logic               drop;
    logic               eoa;
  } hull_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic signed [15:0] px_i = '0;
  logic signed [15:0] py_i = '0;
  logic last_point_i = 1'b0;
  logic busy;
  logic result_valid_o;
  logic signed [15:0] hull_x_o;
  logic signed [15:0] hull_y_o;
  logic [6:0] hull_count_o;
  logic none_found_o;
  logic dropped_o;
  logic end_of_answer_o;

  brute_force_convex_hull_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .px_i(px_i), .py_i(py_i), .last_point_i(last_point_i),
    .result_valid_o(result_valid_o), .hull_x_o(hull_x_o), .hull_y_o(hull_y_o),
    .hull_count_o(hull_count_o), .none_found_o(none_found_o),
    .dropped_o(dropped_o), .end_of_answer_o(end_of_answer_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  point_xfer_t pending_points[$];
  hull_res_t   hull_answers[$];

  // The predictor's own copy of the point store and run flags.
  logic signed [15:0] set_x[bfch_pkg::MaxPoints];
  logic signed [15:0] set_y[bfch_pkg::MaxPoints];
  int  set_len = 0;
  bit  set_overflow = 1'b0;
  int  mismatches = 0;
  longint cycles = 0;
  logic xfer_done = 1'b0;
  int  gap_left = 0;

  // A point (i) is on the hull when some other point (j) leaves no point strictly
  // to the right of the directed line i->j; products are exact in 64 bits.
  task automatic solve_hull_set();
    bit marked[bfch_pkg::MaxPoints];
    logic [31:0] uniq[$];
    logic [31:0] key;
    int pos;
    longint cr;
    bit clear_side;
    hull_res_t r;
    for (int i = 0; i < set_len; i++) begin
      marked[i] = 1'b0;
      for (int j = 0; j < set_len; j++) begin
        if (i == j) continue;
        clear_side = 1'b1;
        for (int k = 0; k < set_len; k++) begin
          if (k == i || k == j) continue;
          cr = (longint'(set_x[j]) - set_x[i]) * (longint'(set_y[k]) - set_y[i])
             - (longint'(set_y[j]) - set_y[i]) * (longint'(set_x[k]) - set_x[i]);
          if (cr < 0) clear_side = 1'b0;
        end
        if (clear_side) marked[i] = 1'b1;
      end
      // Unsigned key order matches signed (x, y) order; repeats collapse to one.
      if (marked[i]) begin
        key = {set_x[i], set_y[i]} ^ 32'h8000_8000;
        pos = 0;
        while (pos < uniq.size() && uniq[pos] < key) pos++;
        if (pos == uniq.size() || uniq[pos] != key) uniq.insert(pos, key);
      end
    end
    if (uniq.size() == 0) begin
      r = '{x: '0, y: '0, count: '0, none: 1'b1, drop: set_overflow, eoa: 1'b1};
      hull_answers.insert(hull_answers.size(), r);
    end else begin
      foreach (uniq[i]) begin
        r.x = 16'(uniq[i][31:16] ^ 16'h8000);
        r.y = 16'(uniq[i][15:0] ^ 16'h8000);
        r.count = 7'(uniq.size());
        r.none = 1'b0;
        r.drop = set_overflow;
        r.eoa = (i == uniq.size() - 1);
        hull_answers.insert(hull_answers.size(), r);
      end
    end
    set_len = 0;
    set_overflow = 1'b0;
  endtask

  // Acceptance and result checking, both at the rising edge.
  always @(posedge clk_i) begin
    hull_res_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    xfer_done <= start && !busy && rst_ni;
    if (start && !busy && rst_ni) begin
      if (set_len < bfch_pkg::MaxPoints) begin
        set_x[set_len] = px_i;
        set_y[set_len] = py_i;
        set_len++;
      end else begin
        set_overflow = 1'b1;
      end
      if (last_point_i) solve_hull_set();
    end
    if (result_valid_o && rst_ni) begin
      if (hull_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer x=%0d y=%0d", hull_x_o, hull_y_o);
      end else begin
        e = hull_answers.pop_front();
        if (hull_x_o !== e.x || hull_y_o !== e.y || hull_count_o !== e.count ||
            none_found_o !== e.none || dropped_o !== e.drop ||
            end_of_answer_o !== e.eoa) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp x=%0d y=%0d cnt=%0d none=%b drop=%b eoa=%b",
                     e.x, e.y, e.count, e.none, e.drop, e.eoa,
                     " got x=%0d y=%0d cnt=%0d none=%b drop=%b eoa=%b",
                     hull_x_o, hull_y_o, hull_count_o, none_found_o, dropped_o,
                     end_of_answer_o);
        end
      end
    end
  end

  // Point driver: changes inputs at the falling edge. A held start stays up until
  // its transfer is seen; gaps are mostly zero or short, now and then long.
  always @(negedge clk_i) begin
    point_xfer_t p;
    logic nxt_start;
    nxt_start = start;
    if (rst_ni && (!start || xfer_done)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_points.size() != 0) begin
        p = pending_points.pop_front();
        px_i <= p.x;
        py_i <= p.y;
        last_point_i <= p.last;
        nxt_start = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: gap_left = 0;
          6, 7, 8:          gap_left = $urandom_range(1, 3);
          default:          gap_left = $urandom_range(10, 40);
        endcase
      end
    end
    start <= nxt_start;
  end

  task automatic add_point(input int x, input int y, input bit last);
    point_xfer_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.last = last;
    pending_points.insert(pending_points.size(), p);
  endtask

  // A random set: full range, a tight cluster (many collinear and repeated
  // points) or extreme x values with y extreme or zero.
  task automatic add_random_set(input int n);
    int flavor;
    int x;
    int y;
    flavor = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: begin
          x = $urandom_range(0, 6) - 3;
          y = $urandom_range(0, 6) - 3;
        end
        default: begin
          x = $urandom_range(0, 1) ? 32767 : -32768;
          y = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
        end
      endcase
      add_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    // Directed sets: a lone point gives no hull, two points and a duplicate pair,
    // the extreme corners with an interior point, a collinear row, a repeated
    // hull vertex.
    add_point(-32768, 32767, 1);
    add_point(5, -7, 0);  add_point(-5, 7, 1);
    add_point(9, 9, 0);   add_point(9, 9, 1);
    add_point(-32768, -32768, 0); add_point(32767, -32768, 0);
    add_point(32767, 32767, 0);   add_point(-32768, 32767, 0);
    add_point(0, 0, 1);
    add_point(-3, -3, 0); add_point(0, 0, 0); add_point(3, 3, 0); add_point(6, 6, 1);
    add_point(0, 0, 0); add_point(10, 0, 0); add_point(0, 10, 0);
    add_point(10, 0, 0); add_point(2, 2, 1);

    // Random part: small sets, plus one overfilled set whose closing point is
    // itself dropped.
    add_random_set(66);
    while (pending_points.size() < 132)
      add_random_set($urandom_range(0, 4) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 7));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pending_points.size() != 0 || start || busy || hull_answers.size() != 0);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && hull_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ brute_force_convex_hull_top.f @@
sv/bfch_pkg.sv
sv/bfch_cross.sv
sv/brute_force_convex_hull_top.sv
tb/sv/tb_top.sv
